>>> rtl/ept_pkg.sv
// shared types and constants for the encoder position tracker
package ept_pkg;

    localparam int RING_DEPTH_DEF = 30;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_W      = 41;
    localparam int INIT_QBITS = 17;
    localparam int POS_QBITS  = 8;
    localparam int CIRC_QBITS = 11;
    localparam int STEP_W     = 5;

    localparam logic [15:0] CENTER_RST    = 16'd8000;
    localparam logic [15:0] SAVED_MAX_RST = 16'd8000;
    localparam logic [15:0] SAVED_MIN_RST = 16'd8000;
    localparam logic [6:0]  SAVED_PCT_RST = 7'd0;
    localparam logic [7:0]  THRESH_RST    = 8'd10;
    localparam logic [7:0]  DEF_CIRC_RST  = 8'd70;
    localparam logic [9:0]  MAX_CIRC_RST  = 10'd100;

    localparam logic signed [31:0] COUNT_RST = 32'sd8000;
    localparam logic signed [31:0] CNT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CNT_MIN   = 32'sh8000_0000;

    localparam logic [6:0]  PCT_FULL   = 7'd100;
    localparam logic [6:0]  PCT_SCALE  = 7'd100;
    localparam logic [15:0] US_PER_MS  = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAVED_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAVED_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAVED_PCT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_CIRC  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CIRC  = 3'd6;

    typedef enum logic [1:0] {
        FN_EDGE,
        FN_TICK,
        FN_CENTER,
        FN_INIT
    } func_t;

    typedef enum logic [1:0] {
        MS_CLOSING,
        MS_STOPPED,
        MS_OPENING
    } motion_t;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_POS,
        OP_CIRC
    } div_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_POS,
        S_CIRC,
        S_DIV,
        S_FIN,
        S_OUT
    } state_t;

endpackage

>>> rtl/ept_ram.sv
// generic single write port ram with registered read
module ept_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 30,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/encoder_position_tracker.sv
// encoder position tracker top level with shared restoring divider
//
// Input channel s_*: one item per handshake, s_func selects encoder edge,
// periodic tick, reset to centre or init from saved limits. Every item
// gives exactly one result on the m_* channel: percent position,
// direction, motion status, one-shot publish flag, averaged edge interval
// in ms and the signed count. Registers are to be written through cfg_*
// only while idle (not enforced by the block); cfg_ready is always high.
// One item is taken at a time. A single restoring divider, one quotient
// bit per cycle, runs the position division (8 steps) and the circle-time
// division (11 steps); an init item first runs it for 17 steps to place
// the count. The position or circle-time division is skipped when the
// travel window or the interval ring is empty. The ring keeps a running
// sum, so no walk over its entries is needed. s_ready is high only in
// idle, so a new item is taken only after the last result has entered
// the output register. A finished result waits there while the next item
// is taken; if the receiver stalls, the next result holds in its last
// step until the register frees. Reset (synchronous, active low) restores
// the configuration, state and tracking registers to their defaults and
// empties the ring; no clearing pass is needed.
module encoder_position_tracker
    import ept_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_func,
    input  logic                   s_b_level,
    input  logic [31:0]            s_time_us,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [6:0]             m_position_percent,
    output logic                   m_direction,
    output logic [1:0]             m_motion_status,
    output logic                   m_publish_now,
    output logic [9:0]             m_circle_time_ms,
    output logic signed [31:0]     m_current_count,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = 32 + CNT_W;

    // configuration
    logic [15:0] center_reg, smax_reg, smin_reg;
    logic [6:0]  spct_reg;
    logic [7:0]  thr_reg, defc_reg;
    logic [9:0]  maxc_reg;

    // control and tracking state
    state_t             state_reg, state_next;
    func_t              func_reg, func_next;
    logic               lvl_reg, lvl_next;
    logic [31:0]        time_reg, time_next;
    logic signed [31:0] count_reg, count_next;
    logic signed [31:0] tmax_reg, tmax_next;
    logic signed [31:0] tmin_reg, tmin_next;
    logic               dir_reg, dir_next;
    motion_t            status_reg, status_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic               edge_seen_reg, edge_seen_next;
    logic [IDX_W-1:0]   ring_idx_reg, ring_idx_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [31:0] last_tick_reg, last_tick_next;
    logic               tick_seen_reg, tick_seen_next;
    logic               pub_armed_reg, pub_armed_next;
    logic               pub_reg, pub_next;
    logic               m_valid_reg, m_valid_next;

    // divider and result payload
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [DIV_W-1:0]      dsh_reg, dsh_next;
    logic [INIT_QBITS-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    div_op_t               op_reg, op_next;
    logic                  neg_reg, neg_next;
    logic [6:0]            pos_reg, pos_next;
    logic [9:0]            circ_reg, circ_next;

    logic [6:0]         out_pos_reg;
    logic               out_dir_reg;
    logic [1:0]         out_status_reg;
    logic               out_pub_reg;
    logic [9:0]         out_circ_reg;
    logic signed [31:0] out_count_reg;
    logic               out_load;

    // ring memory
    logic        ram_we;
    logic [31:0] ram_wdata;
    logic [31:0] ram_rdata;

    // datapath helpers
    logic [31:0]           interval;
    logic signed [31:0]    cnt_up, cnt_dn;
    logic signed [33:0]    tdiff, thr_s;
    logic signed [16:0]    idiff;
    logic signed [24:0]    iprod;
    logic [23:0]           iabs;
    logic signed [31:0]    iq;
    logic signed [33:0]    pdiff, pden;
    logic [32:0]           pabs_num, pabs_den;
    logic [DIV_W-1:0]      pnum_ext, pnum;
    logic [15:0]           circ_den;
    logic [DIV_W:0]        trial;
    logic                  fits;
    logic [POS_QBITS-1:0]  pq;
    logic [CIRC_QBITS-1:0] cq;
    logic                  moving;

    ept_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ring_idx_reg),
        .wdata (ram_wdata),
        .raddr (ring_idx_reg),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    assign interval = time_reg - last_time_reg;
    assign cnt_up   = (count_reg == CNT_MAX) ? count_reg : count_reg + 32'sd1;
    assign cnt_dn   = (count_reg == CNT_MIN) ? count_reg : count_reg - 32'sd1;

    assign tdiff = 34'(count_reg) - 34'(last_tick_reg);
    assign thr_s = {26'b0, thr_reg};

    assign idiff = $signed({1'b0, smax_reg}) - $signed({1'b0, smin_reg});
    assign iprod = $signed({1'b0, spct_reg}) * idiff;
    assign iabs  = iprod[24] ? 24'(-iprod) : iprod[23:0];
    assign iq    = {{(32-INIT_QBITS){1'b0}}, quo_reg};

    assign pdiff    = 34'(count_reg) - 34'(tmin_reg);
    assign pden     = 34'(tmax_reg) - 34'(tmin_reg);
    assign pabs_num = pdiff[33] ? 33'(-pdiff) : pdiff[32:0];
    assign pabs_den = pden[33] ? 33'(-pden) : pden[32:0];
    assign pnum_ext = DIV_W'(pabs_num);
    assign pnum     = (pnum_ext << 6) + (pnum_ext << 5) + (pnum_ext << 2);

    assign circ_den = 16'(fill_reg) * US_PER_MS;

    assign trial = {1'b0, rem_reg} - {1'b0, dsh_reg};
    assign fits  = !trial[DIV_W];

    assign pq     = quo_reg[POS_QBITS-1:0];
    assign cq     = quo_reg[CIRC_QBITS-1:0];
    assign moving = (status_reg != MS_STOPPED);

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        lvl_next       = lvl_reg;
        time_next      = time_reg;
        count_next     = count_reg;
        tmax_next      = tmax_reg;
        tmin_next      = tmin_reg;
        dir_next       = dir_reg;
        status_next    = status_reg;
        last_time_next = last_time_reg;
        edge_seen_next = edge_seen_reg;
        ring_idx_next  = ring_idx_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        last_tick_next = last_tick_reg;
        tick_seen_next = tick_seen_reg;
        pub_armed_next = pub_armed_reg;
        pub_next       = pub_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        op_next        = op_reg;
        neg_next       = neg_reg;
        pos_next       = pos_reg;
        circ_next      = circ_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = interval;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next  = func_t'(s_func);
                    lvl_next   = s_b_level;
                    time_next  = s_time_us;
                    pub_next   = 1'b0;
                    state_next = S_APPLY;
                end
            end

            S_APPLY: begin
                state_next = S_POS;
                case (func_reg)
                    FN_EDGE: begin
                        dir_next = lvl_reg;
                        if (edge_seen_reg) begin
                            ram_we   = 1'b1;
                            sum_next = sum_reg + SUM_W'(interval)
                                     - ((fill_reg == CNT_W'(RING_DEPTH)) ?
                                        SUM_W'(ram_rdata) : '0);
                            ring_idx_next = (ring_idx_reg == IDX_W'(RING_DEPTH - 1)) ?
                                            '0 : ring_idx_reg + 1'b1;
                            if (fill_reg != CNT_W'(RING_DEPTH)) begin
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        last_time_next = time_reg;
                        edge_seen_next = 1'b1;
                        if (lvl_reg) begin
                            count_next = cnt_up;
                            if (cnt_up > tmax_reg) begin
                                tmax_next = cnt_up;
                            end
                        end else begin
                            count_next = cnt_dn;
                            if (cnt_dn < tmin_reg) begin
                                tmin_next = cnt_dn;
                            end
                        end
                    end
                    FN_TICK: begin
                        if (tick_seen_reg) begin
                            if (tdiff >= thr_s) begin
                                dir_next       = 1'b1;
                                status_next    = MS_OPENING;
                                pub_armed_next = 1'b1;
                            end else if (tdiff <= -thr_s) begin
                                dir_next       = 1'b0;
                                status_next    = MS_CLOSING;
                                pub_armed_next = 1'b1;
                            end else begin
                                status_next = MS_STOPPED;
                                if (pub_armed_reg) begin
                                    pub_next       = 1'b1;
                                    pub_armed_next = 1'b0;
                                end
                            end
                        end
                        last_tick_next = count_reg;
                        tick_seen_next = 1'b1;
                    end
                    FN_CENTER: begin
                        dir_next   = 1'b0;
                        count_next = {16'b0, center_reg};
                        tmax_next  = {16'b0, center_reg};
                        tmin_next  = {16'b0, center_reg};
                    end
                    FN_INIT: begin
                        dir_next   = lvl_reg;
                        tmax_next  = {16'b0, smax_reg};
                        tmin_next  = {16'b0, smin_reg};
                        rem_next   = DIV_W'(iabs);
                        dsh_next   = DIV_W'(PCT_SCALE) << (INIT_QBITS - 1);
                        quo_next   = '0;
                        step_next  = STEP_W'(INIT_QBITS - 1);
                        neg_next   = iprod[24];
                        op_next    = OP_INIT;
                        state_next = S_DIV;
                    end
                    default: ;
                endcase
            end

            S_POS: begin
                if (tmax_reg == tmin_reg) begin
                    pos_next   = (status_reg == MS_CLOSING) ? PCT_FULL : 7'd0;
                    state_next = S_CIRC;
                end else begin
                    rem_next   = pnum;
                    dsh_next   = DIV_W'(pabs_den) << (POS_QBITS - 1);
                    quo_next   = '0;
                    step_next  = STEP_W'(POS_QBITS - 1);
                    neg_next   = pdiff[33] ^ pden[33];
                    op_next    = OP_POS;
                    state_next = S_DIV;
                end
            end

            S_CIRC: begin
                if (fill_reg == '0) begin
                    circ_next  = {2'b0, defc_reg};
                    state_next = S_OUT;
                end else begin
                    rem_next   = DIV_W'(sum_reg);
                    dsh_next   = DIV_W'(circ_den) << (CIRC_QBITS - 1);
                    quo_next   = '0;
                    step_next  = STEP_W'(CIRC_QBITS - 1);
                    op_next    = OP_CIRC;
                    state_next = S_DIV;
                end
            end

            S_DIV: begin
                rem_next  = fits ? trial[DIV_W-1:0] : rem_reg;
                quo_next  = {quo_reg[INIT_QBITS-2:0], fits};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = S_FIN;
                end
            end

            S_FIN: begin
                case (op_reg)
                    OP_INIT: begin
                        count_next = $signed({16'b0, smin_reg}) + (neg_reg ? -iq : iq);
                        state_next = S_POS;
                    end
                    OP_POS: begin
                        if (pq == '0 || neg_reg) begin
                            pos_next = moving ? PCT_FULL : 7'd0;
                        end else if (pq >= POS_QBITS'(PCT_FULL)) begin
                            pos_next = moving ? 7'd0 : PCT_FULL;
                        end else begin
                            pos_next = pq[6:0];
                        end
                        state_next = S_CIRC;
                    end
                    OP_CIRC: begin
                        if (cq == '0 || cq > {1'b0, maxc_reg}) begin
                            circ_next = {2'b0, defc_reg};
                        end else begin
                            circ_next = cq[9:0];
                        end
                        state_next = S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end

            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg    <= CENTER_RST;
            smax_reg      <= SAVED_MAX_RST;
            smin_reg      <= SAVED_MIN_RST;
            spct_reg      <= SAVED_PCT_RST;
            thr_reg       <= THRESH_RST;
            defc_reg      <= DEF_CIRC_RST;
            maxc_reg      <= MAX_CIRC_RST;
            state_reg     <= S_IDLE;
            count_reg     <= COUNT_RST;
            tmax_reg      <= COUNT_RST;
            tmin_reg      <= COUNT_RST;
            dir_reg       <= 1'b0;
            status_reg    <= MS_STOPPED;
            last_time_reg <= '0;
            edge_seen_reg <= 1'b0;
            ring_idx_reg  <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            last_tick_reg <= '0;
            tick_seen_reg <= 1'b0;
            pub_armed_reg <= 1'b1;
            pub_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_CENTER:    center_reg <= cfg_data;
                    REG_SAVED_MAX: smax_reg   <= cfg_data;
                    REG_SAVED_MIN: smin_reg   <= cfg_data;
                    REG_SAVED_PCT: spct_reg   <= cfg_data[6:0];
                    REG_THRESH:    thr_reg    <= cfg_data[7:0];
                    REG_DEF_CIRC:  defc_reg   <= cfg_data[7:0];
                    REG_MAX_CIRC:  maxc_reg   <= cfg_data[9:0];
                    default: ;
                endcase
            end
            state_reg     <= state_next;
            count_reg     <= count_next;
            tmax_reg      <= tmax_next;
            tmin_reg      <= tmin_next;
            dir_reg       <= dir_next;
            status_reg    <= status_next;
            last_time_reg <= last_time_next;
            edge_seen_reg <= edge_seen_next;
            ring_idx_reg  <= ring_idx_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            last_tick_reg <= last_tick_next;
            tick_seen_reg <= tick_seen_next;
            pub_armed_reg <= pub_armed_next;
            pub_reg       <= pub_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg <= func_next;
        lvl_reg  <= lvl_next;
        time_reg <= time_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        op_reg   <= op_next;
        neg_reg  <= neg_next;
        pos_reg  <= pos_next;
        circ_reg <= circ_next;
        if (out_load) begin
            out_pos_reg    <= pos_reg;
            out_dir_reg    <= dir_reg;
            out_status_reg <= status_reg;
            out_pub_reg    <= pub_reg;
            out_circ_reg   <= circ_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_position_percent = out_pos_reg;
    assign m_direction        = out_dir_reg;
    assign m_motion_status    = out_status_reg;
    assign m_publish_now      = out_pub_reg;
    assign m_circle_time_ms   = out_circ_reg;
    assign m_current_count    = out_count_reg;

endmodule

>>> rtl/ept_checker.sv
// port level checks for the encoder position tracker and their bind
module ept_checker
    import ept_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [6:0]            m_position_percent,
    input logic [1:0]            m_motion_status,
    input logic                  m_publish_now,
    input logic [9:0]            m_circle_time_ms,
    input logic signed [31:0]    m_current_count
);

    // publish only reported together with a stop
    a_pub_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_publish_now |-> m_motion_status == MS_STOPPED)
        else $error("publish flag without stopped status");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_position_percent <= PCT_FULL)
        else $error("position percent above full scale");

    // one item at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new item taken while busy");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_current_count)
            && $stable(m_position_percent) && $stable(m_circle_time_ms))
        else $error("stalled item changed");

endmodule

bind encoder_position_tracker ept_checker u_ept_checker (.*);

>>> tb/sv/ept_tracker_check.sv
// predicts encoder tracker results from the observed channels and checks each result
module ept_tracker_check
    import ept_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic                  s_b_level,
    input  logic [31:0]           s_time_us,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [6:0]            m_position_percent,
    input  logic                  m_direction,
    input  logic [1:0]            m_motion_status,
    input  logic                  m_publish_now,
    input  logic [9:0]            m_circle_time_ms,
    input  logic signed [31:0]    m_current_count,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_N = RING_DEPTH_DEF;

    typedef struct {
        logic [6:0]         pos;
        logic               dir;
        motion_t            status;
        logic               pub;
        logic [9:0]         circ;
        logic signed [31:0] cnt;
    } tracker_report_t;

    logic [15:0] center_val, smax_val, smin_val;
    logic [6:0]  spct_val;
    logic [7:0]  thr_val, def_circ_val;
    logic [9:0]  max_circ_val;

    logic signed [31:0] cnt, tmax, tmin, last_tick;
    logic               dir, edge_seen, tick_seen, pub_armed, pub_flag;
    motion_t            status;
    logic [31:0]        last_edge;
    logic [31:0]        ring [RING_N];
    int                 ring_idx, ring_fill;

    tracker_report_t expected_reports [$];

    function automatic void restore_defaults();
        center_val   = CENTER_RST;
        smax_val     = SAVED_MAX_RST;
        smin_val     = SAVED_MIN_RST;
        spct_val     = SAVED_PCT_RST;
        thr_val      = THRESH_RST;
        def_circ_val = DEF_CIRC_RST;
        max_circ_val = MAX_CIRC_RST;
        cnt       = COUNT_RST;
        tmax      = COUNT_RST;
        tmin      = COUNT_RST;
        dir       = 1'b0;
        status    = MS_STOPPED;
        last_edge = '0;
        edge_seen = 1'b0;
        foreach (ring[i]) ring[i] = '0;
        ring_idx  = 0;
        ring_fill = 0;
        last_tick = '0;
        tick_seen = 1'b0;
        pub_armed = 1'b1;
        pub_flag  = 1'b0;
    endfunction

    function automatic logic [6:0] percent_now();
        longint num, den, t;
        logic   moving;
        moving = (status != MS_STOPPED);
        if (tmax == tmin) return (status == MS_CLOSING) ? 7'd100 : 7'd0;
        num = 100 * (longint'(cnt) - longint'(tmin));
        den = longint'(tmax) - longint'(tmin);
        t = num / den;
        if (t <= 0) return moving ? 7'd100 : 7'd0;
        if (t >= 100) return moving ? 7'd0 : 7'd100;
        return 7'(t);
    endfunction

    function automatic logic [9:0] circle_now();
        longint unsigned acc, avg;
        acc = 0;
        if (ring_fill == 0) return 10'(def_circ_val);
        for (int i = 0; i < ring_fill; i++) acc += ring[i];
        avg = acc / (longint'(ring_fill) * 1000);
        if (avg == 0 || avg > max_circ_val) return 10'(def_circ_val);
        return 10'(avg);
    endfunction

    function automatic void track_item(logic [1:0] f, logic b, logic [31:0] t_us);
        longint d, mx, mn;
        pub_flag = 1'b0;
        case (func_t'(f))
            FN_EDGE: begin
                dir = b;
                if (edge_seen) begin
                    if (ring_idx >= RING_N) ring_idx = 0;
                    ring[ring_idx] = t_us - last_edge;
                    ring_idx = (ring_idx + 1) % RING_N;
                    if (ring_fill < RING_N) ring_fill++;
                end
                last_edge = t_us;
                edge_seen = 1'b1;
                if (b) begin
                    if (cnt != CNT_MAX) cnt++;
                    if (cnt > tmax) tmax = cnt;
                end else begin
                    if (cnt != CNT_MIN) cnt--;
                    if (cnt < tmin) tmin = cnt;
                end
            end
            FN_TICK: begin
                if (tick_seen) begin
                    d = longint'(cnt) - longint'(last_tick);
                    if (d >= longint'(thr_val)) begin
                        dir = 1'b1;
                        status = MS_OPENING;
                        pub_armed = 1'b1;
                    end else if (-d >= longint'(thr_val)) begin
                        dir = 1'b0;
                        status = MS_CLOSING;
                        pub_armed = 1'b1;
                    end else begin
                        status = MS_STOPPED;
                        if (pub_armed) begin
                            pub_flag = 1'b1;
                            pub_armed = 1'b0;
                        end
                    end
                end
                last_tick = cnt;
                tick_seen = 1'b1;
            end
            FN_CENTER: begin
                dir  = 1'b0;
                cnt  = 32'(center_val);
                tmax = cnt;
                tmin = cnt;
            end
            default: begin
                mx   = longint'(smax_val);
                mn   = longint'(smin_val);
                tmax = 32'(mx);
                tmin = 32'(mn);
                cnt  = 32'(longint'(spct_val) * (mx - mn) / 100 + mn);
                dir  = b;
            end
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        tracker_report_t want;
        if (!aresetn) begin
            restore_defaults();
            expected_reports.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CENTER:    center_val   = cfg_data;
                    REG_SAVED_MAX: smax_val     = cfg_data;
                    REG_SAVED_MIN: smin_val     = cfg_data;
                    REG_SAVED_PCT: spct_val     = cfg_data[6:0];
                    REG_THRESH:    thr_val      = cfg_data[7:0];
                    REG_DEF_CIRC:  def_circ_val = cfg_data[7:0];
                    REG_MAX_CIRC:  max_circ_val = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t: count %0d", $realtime,
                                 m_current_count);
                end else begin
                    want = expected_reports.pop_front();
                    if (m_position_percent !== want.pos || m_direction !== want.dir ||
                        m_motion_status !== want.status || m_publish_now !== want.pub ||
                        m_circle_time_ms !== want.circ || m_current_count !== want.cnt) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result mismatch at %0t: want pos %0d dir %0d ",
                                      "st %0d pub %0d circ %0d cnt %0d, got pos %0d dir %0d ",
                                      "st %0d pub %0d circ %0d cnt %0d"}, $realtime,
                                     want.pos, want.dir, want.status, want.pub, want.circ,
                                     want.cnt, m_position_percent, m_direction,
                                     m_motion_status, m_publish_now, m_circle_time_ms,
                                     m_current_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                track_item(s_func, s_b_level, s_time_us);
                want.pos    = percent_now();
                want.dir    = dir;
                want.status = status;
                want.pub    = pub_flag;
                want.circ   = circle_now();
                want.cnt    = cnt;
                expected_reports.push_back(want);
            end
        end
        outstanding = expected_reports.size();
    end

endmodule

>>> tb/sv/testbench.sv
// top of the encoder tracker testbench: clock, reset, stimulus phases and verdict
module testbench
    import ept_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 116;
    localparam int SETTLE      = 64;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_func    = '0;
    logic                  s_b_level = 1'b0;
    logic [31:0]           s_time_us = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b1;
    logic [6:0]            m_position_percent;
    logic                  m_direction;
    logic [1:0]            m_motion_status;
    logic                  m_publish_now;
    logic [9:0]            m_circle_time_ms;
    logic signed [31:0]    m_current_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          errors, pending;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          sent       = 0;
    int          quiet      = 0;
    int          thr_set    = 10;
    logic [31:0] now_us     = '0;

    encoder_position_tracker uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_b_level          (s_b_level),
        .s_time_us          (s_time_us),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_position_percent (m_position_percent),
        .m_direction        (m_direction),
        .m_motion_status    (m_motion_status),
        .m_publish_now      (m_publish_now),
        .m_circle_time_ms   (m_circle_time_ms),
        .m_current_count    (m_current_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    ept_tracker_check tracker_check (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_b_level          (s_b_level),
        .s_time_us          (s_time_us),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_position_percent (m_position_percent),
        .m_direction        (m_direction),
        .m_motion_status    (m_motion_status),
        .m_publish_now      (m_publish_now),
        .m_circle_time_ms   (m_circle_time_ms),
        .m_current_count    (m_current_count),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatches         (errors),
        .outstanding        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic put_item(input logic [1:0] f, input logic b, input logic [31:0] t_us);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) gap = $urandom_range(40, 1);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= f;
        s_b_level <= b;
        s_time_us <= t_us;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_settings(input logic [15:0] center, input logic [15:0] smax,
                                 input logic [15:0] smin, input logic [6:0] spct,
                                 input logic [7:0] thr, input logic [7:0] def_circ,
                                 input logic [9:0] max_circ);
        put_reg(REG_CENTER, center);
        put_reg(REG_SAVED_MAX, smax);
        put_reg(REG_SAVED_MIN, smin);
        put_reg(REG_SAVED_PCT, 16'(spct));
        put_reg(REG_THRESH, 16'(thr));
        put_reg(REG_DEF_CIRC, 16'(def_circ));
        put_reg(REG_MAX_CIRC, 16'(max_circ));
        cfg_valid <= 1'b0;
        thr_set = int'(thr);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [31:0] edge_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1100000, 1000);
        if (r < 90) return $urandom_range(999);
        return $urandom;
    endfunction

    task automatic run_phase(input int quota);
        int   first, n, r;
        logic lvl;
        first = sent;
        while (sent - first < quota) begin
            r = $urandom_range(99);
            if (r < 70) begin
                // a run of edges, then one or two ticks to judge it
                lvl = 1'($urandom_range(1));
                n = $urandom_range(2 * thr_set + 2);
                if (n > 60) n = $urandom_range(60);
                repeat (n) begin
                    if ($urandom_range(99) < 8) lvl = ~lvl;
                    now_us += edge_gap();
                    put_item(FN_EDGE, lvl, now_us);
                end
                put_item(FN_TICK, 1'($urandom_range(1)), $urandom);
                if ($urandom_range(99) < 40)
                    put_item(FN_TICK, 1'($urandom_range(1)), $urandom);
            end else if (r < 78) begin
                put_item(FN_CENTER, 1'($urandom_range(1)), $urandom);
            end else if (r < 86) begin
                put_item(FN_INIT, 1'($urandom_range(1)), $urandom);
            end else begin
                put_item(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] smax, smin;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults after reset
        put_item(FN_EDGE, 1'b1, 32'h0000_0000);
        put_item(FN_EDGE, 1'b0, 32'hFFFF_FFFF);
        put_item(FN_EDGE, 1'b1, 32'd50000);
        repeat (3) put_item(FN_TICK, 1'b0, 32'h0);
        put_item(FN_INIT, 1'b1, 32'h0);
        put_item(FN_CENTER, 1'b1, 32'hFFFF_FFFF);
        now_us = 32'd50000;
        repeat (11) begin
            now_us += 32'd40000;
            put_item(FN_EDGE, 1'b1, now_us);
        end
        repeat (2) put_item(FN_TICK, 1'b1, 32'hFFFF_FFFF);
        repeat (3) begin
            now_us += 32'd60000;
            put_item(FN_EDGE, 1'b0, now_us);
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            if (p == 0) begin
                load_settings(16'd0, 16'd0, 16'd0, 7'd0, 8'd1, 8'd1, 10'd1);
            end else if (p == 1) begin
                load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd100, 8'd255, 8'd255, 10'd1000);
            end else begin
                smax = 16'($urandom_range(65535));
                smin = 16'($urandom_range(65535));
                if (p == 2) begin
                    smax = 16'hFFFF;
                    smin = 16'h0000;
                end
                load_settings(16'($urandom_range(65535)), smax, smin,
                              7'($urandom_range(100)), 8'($urandom_range(40, 1)),
                              8'($urandom_range(255, 1)), 10'($urandom_range(1000, 30)));
            end
            run_phase(PHASE_ITEMS);
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
